// File: hdl/iida_pkg.sv
`timescale 1ns / 1ps
package iida_pkg;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_DELETE   = 2'd1;
    localparam logic [1:0] CMD_TRAVERSE = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_BADIDX = 2'd3;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 5;
    localparam int POS_W   = 7;

    typedef enum logic {
        ST_IDLE,
        ST_TRAV
    } state_t;

    typedef struct packed {
        logic accept;
        logic trav_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/iida_ctrl.sv
`timescale 1ns / 1ps
module iida_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_cmd,
    output logic                 s_ready,
    input  iida_pkg::dp_stat_t   stat,
    output iida_pkg::ctrl_cmd_t  cmd
);
    import iida_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_cmd == CMD_TRAVERSE && !stat.count_zero) begin
                    state_next = ST_TRAV;
                end
            end
            ST_TRAV: begin
                if (stat.out_free && stat.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.trav_emit = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = stat.out_free;
            ST_TRAV: cmd.trav_emit = stat.out_free;
            default: s_ready = 1'b0;
        endcase
        cmd.accept = s_valid && s_ready;
    end

endmodule

// File: hdl/iida_dpath.sv
`timescale 1ns / 1ps
module iida_dpath #(
    parameter int DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iida_pkg::ctrl_cmd_t           cmd,
    output iida_pkg::dp_stat_t            stat,
    input  logic [1:0]                    s_cmd,
    input  logic signed [iida_pkg::POS_W-1:0]   s_position,
    input  logic signed [iida_pkg::WORD_W-1:0]  s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [iida_pkg::WORD_W-1:0]  m_entry_value,
    output logic [iida_pkg::INDEX_W-1:0]  m_entry_index,
    output logic                          m_last
);
    import iida_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

    logic [WORD_W-1:0] store_reg  [DEPTH];
    logic [WORD_W-1:0] store_next [DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [IW-1:0]     oidx_reg, oidx_next;
    logic              last_reg, last_next;

    logic            pos_neg;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] count_ext;
    logic            full, bad_ins, bad_del;
    logic            do_ins, do_del;

    assign pos_neg   = s_position[POS_W-1];
    assign pos_ext   = CMPW'(s_position[POS_W-2:0]);
    assign count_ext = CMPW'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign bad_ins   = pos_neg || (pos_ext > count_ext);
    assign bad_del   = pos_neg || (pos_ext >= count_ext);

    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_last   = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || m_ready;

    assign do_ins = cmd.accept && s_cmd == CMD_INSERT && !full && !bad_ins;
    assign do_del = cmd.accept && s_cmd == CMD_DELETE && !stat.count_zero && !bad_del;

    // each entry loads from its neighbor, so insert and delete shift all entries together
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [CMPW-1:0] IPOS = CMPW'(i);
        logic [WORD_W-1:0] below, above;

        if (i == 0) begin : g_lo
            assign below = '0;
        end else begin : g_mid
            assign below = store_reg[i-1];
        end
        if (i == DEPTH - 1) begin : g_hi
            assign above = store_reg[i];
        end else begin : g_up
            assign above = store_reg[i+1];
        end

        always_comb begin
            store_next[i] = store_reg[i];
            if (do_ins && IPOS == pos_ext) begin
                store_next[i] = s_item_value;
            end else if (do_ins && IPOS > pos_ext) begin
                store_next[i] = below;
            end else if (do_del && IPOS >= pos_ext) begin
                store_next[i] = above;
            end
        end

        always_ff @(posedge aclk) begin
            store_reg[i] <= store_next[i];
        end
    end

    always_comb begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        status_next    = status_reg;
        value_next     = value_reg;
        oidx_next      = oidx_reg;
        last_next      = last_reg;

        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_del) begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.accept) begin
            value_next = '0;
            oidx_next  = '0;
            last_next  = 1'b1;
            unique case (s_cmd)
                CMD_INSERT: begin
                    out_valid_next = 1'b1;
                    if (full) begin
                        status_next = STAT_FULL;
                    end else if (bad_ins) begin
                        status_next = STAT_BADIDX;
                    end else begin
                        status_next = STAT_OK;
                    end
                end
                CMD_DELETE: begin
                    out_valid_next = 1'b1;
                    if (stat.count_zero) begin
                        status_next = STAT_EMPTY;
                    end else if (bad_del) begin
                        status_next = STAT_BADIDX;
                    end else begin
                        status_next = STAT_OK;
                    end
                end
                CMD_TRAVERSE: begin
                    idx_next = '0;
                    if (stat.count_zero) begin
                        out_valid_next = 1'b1;
                        status_next    = STAT_EMPTY;
                    end
                end
                default: ;
            endcase
        end else if (cmd.trav_emit) begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            value_next     = store_reg[idx_reg];
            oidx_next      = idx_reg;
            last_next      = stat.idx_last;
            idx_next       = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        value_reg  <= value_next;
        oidx_reg   <= oidx_next;
        last_reg   <= last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_value = value_reg;
    assign m_entry_index = INDEX_W'(oidx_reg);
    assign m_last        = last_reg;

endmodule

// File: hdl/indexed_insert_delete_array_top.sv
// insert, delete and status-only words: registered result in the cycle after accept,
// one word per cycle when the result side keeps ready high
// traverse: one result per cycle unless stalled, read from the register chain by index
// the input side stalls until the last traverse word has been registered
// synchronous active-low reset clears count, traverse index and output valid;
// stored words are not cleared
`timescale 1ns / 1ps
module indexed_insert_delete_array_top #(
    parameter int DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic signed [iida_pkg::POS_W-1:0]   s_position,
    input  logic signed [iida_pkg::WORD_W-1:0]  s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [iida_pkg::WORD_W-1:0]  m_entry_value,
    output logic [iida_pkg::INDEX_W-1:0]  m_entry_index,
    output logic                          m_last
);
    import iida_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    iida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    iida_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_entry_index (m_entry_index),
        .m_last        (m_last)
    );

endmodule
